/* sv/iorr_pkg.sv */
`timescale 1ns / 1ps
package iorr_pkg;

	localparam int CAPACITY_DEF     = 8;
	localparam int PAYLOAD_BITS_DEF = 64;
	localparam int SEQ_BITS_DEF     = 16;

	localparam int SEQ_PORT_W = 16;
	localparam int PAY_PORT_W = 64;
	localparam int SEQ_EXT_W  = 32;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic [SEQ_PORT_W-1:0] seq_no;
		logic [PAY_PORT_W-1:0] payload;
		logic                  last_packet;
		logic                  channel;
	} pkt_t;

	typedef struct packed {
		logic                  kind;
		logic [SEQ_PORT_W-1:0] seq_out;
		logic [PAY_PORT_W-1:0] payload_out;
		logic                  last_packet_out;
		logic                  channel_out;
		logic                  run_end;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DELIV,
		ST_ACK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic clr_en;
	} tag_ctrl_t;

	typedef struct packed {
		logic hit;
		logic full;
	} tag_status_t;

endpackage

/* sv/iorr_slot_ram.sv */
`timescale 1ns / 1ps
module iorr_slot_ram #(
	parameter int DEPTH = iorr_pkg::CAPACITY_DEF,
	parameter int WIDTH = iorr_pkg::PAYLOAD_BITS_DEF + 1,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/iorr_tag_store.sv */
`timescale 1ns / 1ps
module iorr_tag_store #(
	parameter int CAPACITY = iorr_pkg::CAPACITY_DEF,
	parameter int SEQ_BITS = iorr_pkg::SEQ_BITS_DEF,
	parameter int IDX_W    = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iorr_pkg::tag_ctrl_t   ctrl,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [SEQ_BITS-1:0]   wr_tag,
	input  logic [IDX_W-1:0]      clr_idx,
	input  logic [SEQ_BITS-1:0]   key,
	output iorr_pkg::tag_status_t status,
	output logic [IDX_W-1:0]      hit_idx,
	output logic [IDX_W-1:0]      free_idx
);

	logic [CAPACITY-1:0] valid_q;
	logic [SEQ_BITS-1:0] tag_q [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_vec[i] = valid_q[i] && (tag_q[i] == key);
		end
	end

	// lowest index wins on both searches
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		status.hit  = |hit_vec;
		status.full = &valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctrl.wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctrl.clr_en) begin
				valid_q[clr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			tag_q[wr_idx] <= wr_tag;
		end
	end

endmodule

/* sv/in_order_reorder_receiver_unit.sv */
`timescale 1ns / 1ps
// A packet is accepted only in ST_IDLE and evaluated in ST_EVAL; a dropped one then returns
// to ST_IDLE, a stale, duplicate or stored early packet is acknowledged in ST_ACK, and an
// in-order packet passes ST_DELIV and ST_ACK and then ST_DRAIN for each drained entry; the
// tag search and the registered slot memory read set the drain pace, and an output stall
// holds the current state. Reset (arst_n, asynchronous, active low) clears the state, the
// expected number, all slot valid bits and the output valid flag; slot contents are left as they are.
module in_order_reorder_receiver_unit #(
	parameter int CAPACITY     = iorr_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = iorr_pkg::PAYLOAD_BITS_DEF,
	parameter int SEQ_BITS     = iorr_pkg::SEQ_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pkt_valid,
	output logic           pkt_ready,
	input  iorr_pkg::pkt_t pkt,
	output logic           res_valid,
	input  logic           res_ready,
	output iorr_pkg::res_t res
);

	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int MEM_W    = PAYLOAD_BITS + 1;
	localparam int EXT_W    = iorr_pkg::SEQ_EXT_W;
	localparam int SEQ_PW   = iorr_pkg::SEQ_PORT_W;
	localparam int PAY_PW   = iorr_pkg::PAY_PORT_W;

	iorr_pkg::state_t state_q, state_d;

	logic [SEQ_BITS-1:0]     seq_q, expected_q, drain_seq_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    last_q, chan_q, inorder_q;
	logic                    out_valid_q;
	iorr_pkg::res_t          out_q, out_d;

	logic [EXT_W-1:0]        in_seq_ext;
	logic [SEQ_BITS-1:0]     in_seq;
	logic [SEQ_BITS-1:0]     seq_dist;
	logic                    in_order, early;
	logic                    out_free;

	logic [SEQ_BITS-1:0]     key;
	iorr_pkg::tag_ctrl_t     tag_ctrl;
	iorr_pkg::tag_status_t   tag_st;
	logic [IDX_W-1:0]        hit_idx, free_idx;

	logic                    mem_rd;
	logic [MEM_W-1:0]        rd_data;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic                    rd_last;

	logic                    load_out, exp_inc, drain_ld, accept;
	logic [SEQ_BITS-1:0]     out_seq_sel;
	logic [EXT_W-1:0]        out_seq_ext;
	logic [PAYLOAD_BITS-1:0] out_pay_sel;

	assign in_seq_ext = EXT_W'(pkt.seq_no);
	assign in_seq     = in_seq_ext[SEQ_BITS-1:0];
	assign seq_dist   = seq_q - expected_q;
	assign in_order   = (seq_dist == '0);
	assign early      = !in_order && !seq_dist[SEQ_BITS-1];
	assign out_free   = !out_valid_q || res_ready;
	assign accept     = pkt_valid && pkt_ready;
	assign key        = (state_q == iorr_pkg::ST_EVAL) ? seq_q : expected_q;
	assign rd_pay     = rd_data[PAYLOAD_BITS-1:0];
	assign rd_last    = rd_data[PAYLOAD_BITS];

	iorr_tag_store #(
		.CAPACITY(CAPACITY),
		.SEQ_BITS(SEQ_BITS),
		.IDX_W   (IDX_W)
	) u_tags (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (tag_ctrl),
		.wr_idx  (free_idx),
		.wr_tag  (seq_q),
		.clr_idx (hit_idx),
		.key     (key),
		.status  (tag_st),
		.hit_idx (hit_idx),
		.free_idx(free_idx)
	);

	iorr_slot_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(MEM_W),
		.AW   (IDX_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (tag_ctrl.wr_en),
		.wr_addr(free_idx),
		.wr_data({last_q, pay_q}),
		.rd_en  (mem_rd),
		.rd_addr(hit_idx),
		.rd_data(rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			iorr_pkg::ST_IDLE: begin
				if (pkt_valid) begin
					state_d = iorr_pkg::ST_EVAL;
				end
			end
			iorr_pkg::ST_EVAL: begin
				if (in_order) begin
					state_d = iorr_pkg::ST_DELIV;
				end else if (early && !tag_st.hit && tag_st.full) begin
					state_d = iorr_pkg::ST_IDLE;
				end else begin
					state_d = iorr_pkg::ST_ACK;
				end
			end
			iorr_pkg::ST_DELIV: begin
				if (out_free) begin
					state_d = iorr_pkg::ST_ACK;
				end
			end
			iorr_pkg::ST_ACK: begin
				if (out_free) begin
					state_d = (inorder_q && tag_st.hit) ? iorr_pkg::ST_DRAIN
						: iorr_pkg::ST_IDLE;
				end
			end
			iorr_pkg::ST_DRAIN: begin
				if (out_free && !tag_st.hit) begin
					state_d = iorr_pkg::ST_IDLE;
				end
			end
			default: state_d = iorr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pkt_ready       = 1'b0;
		tag_ctrl.wr_en  = 1'b0;
		tag_ctrl.clr_en = 1'b0;
		mem_rd          = 1'b0;
		load_out        = 1'b0;
		exp_inc         = 1'b0;
		drain_ld        = 1'b0;
		out_d.kind      = iorr_pkg::KIND_DELIVER;
		out_d.run_end   = 1'b0;
		out_d.channel_out = 1'b0;
		out_d.last_packet_out = last_q;
		out_seq_sel     = seq_q;
		out_pay_sel     = '0;
		case (state_q)
			iorr_pkg::ST_IDLE: begin
				pkt_ready = 1'b1;
			end
			iorr_pkg::ST_EVAL: begin
				// store an early packet that is new and fits
				if (early && !tag_st.hit && !tag_st.full) begin
					tag_ctrl.wr_en = 1'b1;
				end
			end
			iorr_pkg::ST_DELIV: begin
				load_out    = out_free;
				exp_inc     = out_free;
				out_pay_sel = pay_q;
			end
			iorr_pkg::ST_ACK: begin
				load_out          = out_free;
				out_d.kind        = iorr_pkg::KIND_ACK;
				out_d.channel_out = chan_q;
				out_d.run_end     = !(inorder_q && tag_st.hit);
				if (out_free && inorder_q && tag_st.hit) begin
					mem_rd          = 1'b1;
					tag_ctrl.clr_en = 1'b1;
					exp_inc         = 1'b1;
					drain_ld        = 1'b1;
				end
			end
			iorr_pkg::ST_DRAIN: begin
				load_out              = out_free;
				out_seq_sel           = drain_seq_q;
				out_pay_sel           = rd_pay;
				out_d.last_packet_out = rd_last;
				out_d.run_end         = !tag_st.hit;
				if (out_free && tag_st.hit) begin
					mem_rd          = 1'b1;
					tag_ctrl.clr_en = 1'b1;
					exp_inc         = 1'b1;
					drain_ld        = 1'b1;
				end
			end
			default: begin
				pkt_ready = 1'b0;
			end
		endcase
		out_seq_ext       = EXT_W'(out_seq_sel);
		out_d.seq_out     = out_seq_ext[SEQ_PW-1:0];
		out_d.payload_out = PAY_PW'(out_pay_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iorr_pkg::ST_IDLE;
			expected_q  <= '0;
			inorder_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == iorr_pkg::ST_EVAL) begin
				inorder_q <= in_order;
			end
			if (exp_inc) begin
				expected_q <= expected_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q  <= in_seq;
			pay_q  <= pkt.payload[PAYLOAD_BITS-1:0];
			last_q <= pkt.last_packet;
			chan_q <= pkt.channel;
		end
		if (drain_ld) begin
			drain_seq_q <= expected_q;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

/* sv/iorr_checker.sv */
`timescale 1ns / 1ps
module iorr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pkt_valid,
	input logic           pkt_ready,
	input logic           res_valid,
	input logic           res_ready,
	input iorr_pkg::res_t res
);

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// one packet at a time: ready drops after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_ready |=> !pkt_ready)
		else $error("input accepted while a packet is in work");

	a_ack_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == iorr_pkg::KIND_ACK) |-> (res.payload_out == '0))
		else $error("acknowledgement carries payload");

	a_deliver_no_chan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == iorr_pkg::KIND_DELIVER) |-> !res.channel_out)
		else $error("delivery carries a channel");

endmodule

bind in_order_reorder_receiver_unit iorr_checker u_iorr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pkt_valid(pkt_valid),
	.pkt_ready(pkt_ready),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res      (res)
);

/* verif/in_order_reorder_receiver_unit_test.sv */
`timescale 1ns / 1ps
module in_order_reorder_receiver_unit_test;

	localparam int SLOTS       = iorr_pkg::CAPACITY_DEF;
	localparam int SEQ_W       = iorr_pkg::SEQ_PORT_W;
	localparam int PAY_W       = iorr_pkg::PAY_PORT_W;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTED = 40;

	logic clk;
	logic arst_n;
	logic pkt_valid;
	logic pkt_ready;
	iorr_pkg::pkt_t pkt;
	logic res_valid;
	logic res_ready;
	iorr_pkg::res_t res;

	in_order_reorder_receiver_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.pkt(pkt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// receive window state, mirrors the block
	logic [SEQ_W-1:0] next_seq;
	logic             held_valid[SLOTS];
	logic [SEQ_W-1:0] held_seq[SLOTS];
	logic [PAY_W-1:0] held_payload[SLOTS];
	logic             held_last[SLOTS];
	int               held_count;

	iorr_pkg::res_t awaited_results[$];
	int   error_count = 0;
	int   pkts_sent;
	int   cycle_count = 0;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_len;
	int   hold_id;
	int   hold_seen = 0;
	int   hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic log_error(string msg);
		if (error_count < MAX_PRINTED)
			$display("[%0t] ERROR: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic iorr_pkg::res_t make_result(logic kind, logic [SEQ_W-1:0] s,
			logic [PAY_W-1:0] pay, logic last, logic chan);
		iorr_pkg::res_t r;
		r.kind            = kind;
		r.seq_out         = s;
		r.payload_out     = pay;
		r.last_packet_out = last;
		r.channel_out     = chan;
		r.run_end         = 1'b0;
		return r;
	endfunction

	function automatic iorr_pkg::pkt_t make_pkt(logic [SEQ_W-1:0] s, logic [PAY_W-1:0] pay,
			logic last, logic chan);
		iorr_pkg::pkt_t p;
		p.seq_no      = s;
		p.payload     = pay;
		p.last_packet = last;
		p.channel     = chan;
		return p;
	endfunction

	function automatic iorr_pkg::pkt_t random_pkt(logic [SEQ_W-1:0] s);
		return make_pkt(s, {$urandom, $urandom}, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endfunction

	function automatic int find_held(logic [SEQ_W-1:0] s);
		for (int i = 0; i < SLOTS; i++)
			if (held_valid[i] && held_seq[i] == s)
				return i;
		return -1;
	endfunction

	function automatic int find_held_free();
		for (int i = 0; i < SLOTS; i++)
			if (!held_valid[i])
				return i;
		return -1;
	endfunction

	// Work out the results one accepted packet causes and queue them.
	task automatic predict_receive(iorr_pkg::pkt_t p);
		logic [SEQ_W-1:0] seq_dist;
		int slot;
		int n;
		iorr_pkg::res_t r;
		n = 0;
		seq_dist = p.seq_no - next_seq;
		if (seq_dist == 0) begin
			awaited_results.push_back(make_result(iorr_pkg::KIND_DELIVER, p.seq_no,
				p.payload, p.last_packet, 1'b0));
			awaited_results.push_back(make_result(iorr_pkg::KIND_ACK, p.seq_no, '0,
				p.last_packet, p.channel));
			n = 2;
			next_seq++;
			slot = find_held(next_seq);
			while (slot >= 0) begin
				awaited_results.push_back(make_result(iorr_pkg::KIND_DELIVER,
					held_seq[slot], held_payload[slot], held_last[slot], 1'b0));
				n++;
				held_valid[slot] = 1'b0;
				if (held_count > 0)
					held_count--;
				next_seq++;
				slot = find_held(next_seq);
			end
		end else if (seq_dist < (1 << (SEQ_W - 1))) begin
			if (find_held(p.seq_no) >= 0) begin
				awaited_results.push_back(make_result(iorr_pkg::KIND_ACK, p.seq_no, '0,
					p.last_packet, p.channel));
				n = 1;
			end else if (held_count < SLOTS) begin
				slot = find_held_free();
				held_valid[slot]   = 1'b1;
				held_seq[slot]     = p.seq_no;
				held_payload[slot] = p.payload;
				held_last[slot]    = p.last_packet;
				held_count++;
				awaited_results.push_back(make_result(iorr_pkg::KIND_ACK, p.seq_no, '0,
					p.last_packet, p.channel));
				n = 1;
			end
			// buffer full: drop, nothing comes out
		end else begin
			awaited_results.push_back(make_result(iorr_pkg::KIND_ACK, p.seq_no, '0,
				p.last_packet, p.channel));
			n = 1;
		end
		if (n > 0) begin
			r = awaited_results.pop_back();
			r.run_end = 1'b1;
			awaited_results.push_back(r);
		end
	endtask

	// Offer one packet; returns right after the edge that accepted it.
	task automatic send_pkt(iorr_pkg::pkt_t p);
		int gap;
		gap = 0;
		while (gap < 16 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt       <= p;
		pkt_valid <= 1'b1;
		do @(posedge clk); while (!pkt_ready);
		predict_receive(p);
		pkts_sent++;
	endtask

	// Hold the input until every queued result has come out.
	task automatic wait_for_drain();
		pkt_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// Send the next n numbers of the window in shuffled order, with the odd repeat.
	task automatic send_window(int n);
		logic [SEQ_W-1:0] win[SLOTS + 4];
		logic [SEQ_W-1:0] tmp;
		int j;
		for (int i = 0; i < n; i++)
			win[i] = next_seq + SEQ_W'(i);
		for (int i = n - 1; i > 0; i--) begin
			j      = $urandom_range(i);
			tmp    = win[i];
			win[i] = win[j];
			win[j] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			send_pkt(random_pkt(win[i]));
			if ($urandom_range(9) == 0)
				send_pkt(random_pkt(win[$urandom_range(i)]));
		end
	endtask

	task automatic compare_field(string name, logic [PAY_W-1:0] got,
			logic [PAY_W-1:0] want);
		if (got !== want)
			log_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	always @(posedge clk) begin
		iorr_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (awaited_results.size() == 0) begin
				log_error($sformatf("unexpected transaction, kind %0d seq 0x%0h",
					res.kind, res.seq_out));
			end else begin
				want = awaited_results.pop_front();
				compare_field("kind", PAY_W'(res.kind), PAY_W'(want.kind));
				compare_field("seq_out", PAY_W'(res.seq_out), PAY_W'(want.seq_out));
				compare_field("payload_out", res.payload_out, want.payload_out);
				compare_field("last_packet_out", PAY_W'(res.last_packet_out),
					PAY_W'(want.last_packet_out));
				compare_field("channel_out", PAY_W'(res.channel_out),
					PAY_W'(want.channel_out));
				compare_field("run_end", PAY_W'(res.run_end), PAY_W'(want.run_end));
			end
		end
	end

	// Output side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_id != hold_seen) begin
			hold_seen = hold_id;
			hold_left = hold_len;
		end
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** in_order_reorder_receiver_unit: FAILED **");
			$finish;
		end
	end

	task automatic test_directed_cases();
		send_pkt(make_pkt(16'd1, '1, 1'b1, 1'b1));      // early, stored
		send_pkt(make_pkt(16'd1, '0, 1'b0, 1'b0));      // duplicate of a held packet
		send_pkt(make_pkt(16'hFFFF, '1, 1'b1, 1'b0));   // behind the window
		send_pkt(make_pkt(16'd0, '0, 1'b0, 1'b1));      // in order, drains 1
		for (int s = 3; s <= 10; s++)
			send_pkt(random_pkt(SEQ_W'(s)));               // fill the buffer
		send_pkt(random_pkt(16'd11));                     // full: dropped
		send_pkt(random_pkt(16'd2 + 16'h7FFF));           // farthest early, full: dropped
		send_pkt(random_pkt(16'd2 + 16'h8000));           // half range away: stale
		send_pkt(make_pkt(16'd5, '1, 1'b0, 1'b1));      // held already, acked while full
		send_pkt(make_pkt(16'd2, '1, 1'b1, 1'b1));      // in order, drains all eight
		send_pkt(make_pkt(16'd11, '0, 1'b1, 1'b0));     // in order, nothing to drain
	endtask

	// Stall the output long enough that the block backs up into its input.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 200;
		hold_id++;
		send_window(SLOTS);
		repeat (4) send_window($urandom_range(1, 4));
	endtask

	task automatic test_random_traffic(int items, int s_idle, int r_idle);
		int stop_at;
		int mode;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		stop_at = pkts_sent + items;
		while (pkts_sent < stop_at) begin
			mode = $urandom_range(99);
			if (mode < 60) begin
				send_window($urandom_range(1, SLOTS + 2));
			end else if (mode < 75) begin
				send_pkt(random_pkt(next_seq - SEQ_W'($urandom_range(1, 20))));
			end else if (mode < 90) begin
				send_pkt(random_pkt(next_seq + SEQ_W'($urandom_range(1, 12))));
			end else if (held_count == SLOTS) begin
				// any number: early ones are dropped, so the buffer stays clean
				send_pkt(random_pkt(SEQ_W'($urandom)));
			end else begin
				send_pkt(random_pkt(next_seq + 16'h8000 + SEQ_W'($urandom_range(16'h7FFF))));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		pkt_valid     = 1'b0;
		pkt           = '0;
		next_seq      = '0;
		held_count    = 0;
		pkts_sent     = 0;
		hold_len      = 0;
		hold_id       = 0;
		send_idle_pct = 17;
		recv_idle_pct = 52;
		for (int i = 0; i < SLOTS; i++)
			held_valid[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		wait_for_drain();
		test_output_backpressure();
		wait_for_drain();
		test_random_traffic(100, 17, 52);
		test_random_traffic(100, 52, 17);
		test_random_traffic(100, 0, 0);

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("** in_order_reorder_receiver_unit: PASSED **");
		else
			$display("** in_order_reorder_receiver_unit: FAILED **");
		$finish;
	end

endmodule
